>>> src/itli_pkg.sv
package itli_pkg;

  localparam int TableDepth = 16;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int DataW      = 32;
  localparam int SumW       = 57;

  localparam logic [4:0] MaxPoints = 5'(TableDepth);

  localparam logic [1:0] FN_LOAD  = 2'd0;
  localparam logic [1:0] FN_EVAL  = 2'd1;
  localparam logic [1:0] FN_INTEG = 2'd2;

  localparam logic [1:0] MODE_ERROR  = 2'd0;
  localparam logic [1:0] MODE_WARN   = 2'd1;
  localparam logic [1:0] MODE_CLAMP  = 2'd2;
  localparam logic [1:0] MODE_REPEAT = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_RANGE = 3'd3;
  localparam logic [2:0] ST_FAULT = 3'd4;

  localparam logic CFG_BOUNDS = 1'b0;
  localparam logic CFG_POINTS = 1'b1;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_LOAD   = 18'h00002,
    S_CHECK  = 18'h00004,
    S_DECIDE = 18'h00008,
    S_DIV    = 18'h00010,
    S_WRAP   = 18'h00020,
    S_SEARCH = 18'h00040,
    S_FRAC   = 18'h00080,
    S_MUL    = 18'h00100,
    S_INTERP = 18'h00200,
    S_BODY   = 18'h00400,
    S_TRD0   = 18'h00800,
    S_TRD1   = 18'h01000,
    S_EDGE   = 18'h02000,
    S_ACC    = 18'h04000,
    S_E1CHK  = 18'h08000,
    S_E2CHK  = 18'h10000,
    S_FIN    = 18'h20000
  } state_e;

  typedef enum logic [2:0] {
    SEL_MAIN  = 3'd0,
    SEL_PAIR1 = 3'd1,
    SEL_PAIR2 = 3'd2,
    SEL_EDGE1 = 3'd3,
    SEL_EDGE2 = 3'd4,
    SEL_BODY  = 3'd5
  } sel_e;

endpackage

>>> src/itli_ram.sv
module itli_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/interp_table_lookup_integrate.sv
// Channel   Direction  Handshake                Word
// input     in         in_valid_i / in_stall_o  func, point_index, abscissa, second_operand
// output    out        out_valid_o / out_stall_i result_value, status
// config    in         cfg_we_i                 cfg_idx_i, cfg_wdata_i
//
// A load word passes through S_LOAD and S_FIN; an evaluate word scans the table, searches
// the interval and runs the divider and multiplier; a repeat wrap also needs the remainder divider.
// An integrate word scans the table, runs the 32-step divider and multiplier for each edge
// evaluation, and runs only the multiplier for each trapezoid term.
// The point memories have one read port each, so table scans move one point a cycle.
// Reset is asynchronous and active low; the table contents are left as they are.
// A new word is taken while a finished result waits under out_stall_i.
module interp_table_lookup_integrate
  import itli_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              func_i,
  input  logic [AddrW-1:0]        point_index_i,
  input  logic signed [DataW-1:0] abscissa_i,
  input  logic signed [DataW-1:0] second_operand_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] result_value_o,
  output logic [2:0]              status_o,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [4:0]              cfg_wdata_i
);

  localparam logic signed [SumW-1:0] SumMax = 57'sd2147483647;
  localparam logic signed [SumW-1:0] SumMin = -57'sd2147483648;

  function automatic logic signed [33:0] sx(logic signed [31:0] v);
    return {{2{v[31]}}, v};
  endfunction

  state_e state_q, state_d;
  sel_e   sel_q, sel_d;
  logic [1:0] mode_q, mode_d;
  logic [4:0] points_q, points_d;
  logic       out_valid_q, out_valid_d;

  logic [1:0]              func_q, func_d;
  logic [AddrW-1:0]        idx_q, idx_d;
  logic signed [31:0]      a_q, a_d, b_q, b_d;
  logic [AddrW-1:0]        addr_q, addr_d;
  logic signed [31:0]      prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic signed [31:0]      x0_q, x0_d, y0_q, y0_d, xl_q, xl_d, yl_q, yl_d;
  logic [AddrW-1:0]        cnt1_q, cnt1_d, cnt2_q, cnt2_d, k_q, k_d;
  logic signed [31:0]      xd_q, xd_d, yi_q, yi_d, e1_q, e1_d;
  logic [31:0]             rem_q, rem_d, dsh_q, dsh_d, div_s_q, div_s_d, quo_q, quo_d;
  logic [4:0]              dcnt_q, dcnt_d;
  logic                    dmod_q, dmod_d, dneg_q, dneg_d, dyneg_q, dyneg_d;
  logic [31:0]             ady_q, ady_d;
  logic [33:0]             ma_q, ma_d, mb_q, mb_d;
  logic                    mneg_q, mneg_d, mtrap_q, mtrap_d;
  logic [1:0]              mcnt_q, mcnt_d;
  logic [50:0]             p0_q, p0_d, p1_q, p1_d;
  logic [67:0]             prod_q, prod_d;
  logic signed [SumW-1:0]  sum_q, sum_d;
  logic signed [31:0]      res_q, res_d, out_res_q, out_res_d;
  logic [2:0]              st_q, st_d, out_st_q, out_st_d;

  logic [31:0]        x_raw, y_raw;
  logic signed [31:0] x_rd, y_rd;
  logic               x_we;

  logic [AddrW-1:0]   last, id2;
  logic               below, above;
  logic [32:0]        trial;
  logic               ge;
  logic signed [33:0] dif, ndif, dy, ndy, ev34, ma_s, mb_s;
  logic [31:0]        span, rr;
  logic [32:0]        mag;
  logic signed [31:0] ev;
  logic [SumW-1:0]    hp;
  logic               mul_go, mtrap_s;

  itli_ram #(.Width(DataW), .Depth(TableDepth)) u_ram_x (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (idx_q),
    .wdata_i (a_q),
    .raddr_i (addr_d),
    .rdata_o (x_raw)
  );

  itli_ram #(.Width(DataW), .Depth(TableDepth)) u_ram_y (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (idx_q),
    .wdata_i (b_q),
    .raddr_i (addr_d),
    .rdata_o (y_raw)
  );

  assign x_rd = $signed(x_raw);
  assign y_rd = $signed(y_raw);

  assign last  = AddrW'(points_q - 5'd1);
  assign id2   = last - cnt2_q;
  assign below = a_q < x0_q;
  assign above = a_q > xl_q;
  assign trial = {rem_q, dsh_q[31]};
  assign ge    = trial >= {1'b0, div_s_q};
  assign dif   = sx(a_q) - sx(x0_q);
  assign ndif  = -dif;
  assign span  = xl_q - x0_q;
  assign rr    = (dneg_q && rem_q != 32'd0) ? div_s_q - rem_q : rem_q;
  assign dy    = sx(y_rd) - sx(prev_y_q);
  assign ndy   = -dy;
  assign mag   = prod_q[63:31];
  assign ev34  = dyneg_q ? sx(yi_q) - $signed({1'b0, mag}) : sx(yi_q) + $signed({1'b0, mag});
  assign ev    = ev34[31:0];
  assign hp    = {6'b0, prod_q[67:17]};

  always_comb begin
    state_d = state_q;  sel_d = sel_q;  mode_d = mode_q;  points_d = points_q;
    out_valid_d = out_valid_q;  out_res_d = out_res_q;  out_st_d = out_st_q;
    func_d = func_q;  idx_d = idx_q;  a_d = a_q;  b_d = b_q;  addr_d = addr_q;
    prev_x_d = prev_x_q;  prev_y_d = prev_y_q;
    x0_d = x0_q;  y0_d = y0_q;  xl_d = xl_q;  yl_d = yl_q;
    cnt1_d = cnt1_q;  cnt2_d = cnt2_q;  k_d = k_q;
    xd_d = xd_q;  yi_d = yi_q;  e1_d = e1_q;
    rem_d = rem_q;  dsh_d = dsh_q;  div_s_d = div_s_q;  quo_d = quo_q;  dcnt_d = dcnt_q;
    dmod_d = dmod_q;  dneg_d = dneg_q;  dyneg_d = dyneg_q;  ady_d = ady_q;
    ma_d = ma_q;  mb_d = mb_q;  mneg_d = mneg_q;  mtrap_d = mtrap_q;  mcnt_d = mcnt_q;
    p0_d = p0_q;  p1_d = p1_q;  prod_d = prod_q;  sum_d = sum_q;
    res_d = res_q;  st_d = st_q;
    x_we = 1'b0;
    mul_go = 1'b0;  mtrap_s = 1'b0;  ma_s = '0;  mb_s = '0;

    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_BOUNDS: mode_d = cfg_wdata_i[1:0];
        CFG_POINTS: points_d = cfg_wdata_i;
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          func_d = func_i;
          idx_d  = point_index_i;
          a_d    = abscissa_i;
          b_d    = second_operand_i;
          res_d  = '0;
          st_d   = ST_OK;
          sum_d  = '0;
          cnt1_d = '0;
          cnt2_d = '0;
          case (func_i)
            FN_LOAD: begin
              addr_d  = point_index_i - AddrW'(1);
              state_d = S_LOAD;
            end
            FN_EVAL, FN_INTEG: begin
              if (points_q == 5'd0 || points_q > MaxPoints) begin
                st_d    = ST_FAULT;
                state_d = S_FIN;
              end else begin
                addr_d  = '0;
                state_d = S_CHECK;
              end
            end
            default: state_d = S_FIN;
          endcase
        end
      end
      S_LOAD: begin
        x_we = 1'b1;
        if (idx_q != '0 && a_q <= x_rd) begin
          st_d = ST_FAULT;
        end
        state_d = S_FIN;
      end
      S_CHECK: begin
        if (addr_q != '0 && x_rd <= prev_x_q) begin
          st_d    = ST_FAULT;
          state_d = S_FIN;
        end else begin
          prev_x_d = x_rd;
          if (addr_q == '0) begin
            x0_d = x_rd;
            y0_d = y_rd;
          end
          if (addr_q != last && x_rd < a_q) begin
            cnt1_d = cnt1_q + AddrW'(1);
          end
          if (addr_q != '0 && x_rd > b_q) begin
            cnt2_d = cnt2_q + AddrW'(1);
          end
          if (addr_q == last) begin
            xl_d    = x_rd;
            yl_d    = y_rd;
            state_d = S_DECIDE;
          end else begin
            addr_d = addr_q + AddrW'(1);
          end
        end
      end
      S_DECIDE: begin
        if (func_q == FN_EVAL) begin
          if (below || above) begin
            case (mode_q)
              MODE_ERROR: begin
                st_d    = ST_RANGE;
                state_d = S_FIN;
              end
              MODE_WARN: begin
                res_d   = below ? y0_q : yl_q;
                st_d    = below ? ST_UNDER : ST_OVER;
                state_d = S_FIN;
              end
              MODE_CLAMP: begin
                res_d   = below ? y0_q : yl_q;
                state_d = S_FIN;
              end
              default: begin
                if (last == '0) begin
                  res_d   = y0_q;
                  state_d = S_FIN;
                end else begin
                  dneg_d  = dif[33];
                  dsh_d   = dif[33] ? ndif[31:0] : dif[31:0];
                  rem_d   = '0;
                  div_s_d = span;
                  dcnt_d  = '0;
                  dmod_d  = 1'b1;
                  state_d = S_DIV;
                end
              end
            endcase
          end else if (last == '0) begin
            res_d   = y0_q;
            state_d = S_FIN;
          end else begin
            xd_d    = a_q;
            sel_d   = SEL_MAIN;
            addr_d  = '0;
            state_d = S_SEARCH;
          end
        end else begin
          sum_d = '0;
          if (a_q > xl_q || b_q < x0_q) begin
            state_d = S_FIN;
          end else if ({1'b0, cnt1_q} == {1'b0, id2} + (AddrW+1)'(1)) begin
            xd_d    = a_q;
            sel_d   = SEL_PAIR1;
            addr_d  = '0;
            state_d = S_SEARCH;
          end else begin
            k_d     = cnt1_q;
            sel_d   = SEL_BODY;
            state_d = S_BODY;
          end
        end
      end
      S_DIV: begin
        rem_d  = ge ? 32'(trial - {1'b0, div_s_q}) : trial[31:0];
        quo_d  = {quo_q[30:0], ge};
        dsh_d  = {dsh_q[30:0], 1'b0};
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd31) begin
          state_d = dmod_q ? S_WRAP : S_FRAC;
        end
      end
      S_WRAP: begin
        xd_d    = x0_q + $signed(rr);
        sel_d   = SEL_MAIN;
        addr_d  = '0;
        state_d = S_SEARCH;
      end
      S_SEARCH: begin
        if (addr_q == '0) begin
          prev_x_d = x_rd;
          prev_y_d = y_rd;
          addr_d   = AddrW'(1);
        end else if (x_rd >= xd_q || addr_q == last) begin
          yi_d    = prev_y_q;
          dyneg_d = dy[33];
          ady_d   = dy[33] ? ndy[31:0] : dy[31:0];
          rem_d   = {1'b0, 31'(32'(xd_q - prev_x_q) >> 1)};
          dsh_d   = {xd_q[0] ^ prev_x_q[0], 31'b0};
          div_s_d = x_rd - prev_x_q;
          dcnt_d  = '0;
          dmod_d  = 1'b0;
          state_d = S_DIV;
        end else begin
          prev_x_d = x_rd;
          prev_y_d = y_rd;
          addr_d   = addr_q + AddrW'(1);
        end
      end
      S_FRAC: begin
        mul_go = 1'b1;
        ma_s   = {2'b0, quo_q};
        mb_s   = {2'b0, ady_q};
      end
      S_MUL: begin
        mcnt_d = mcnt_q + 2'd1;
        case (mcnt_q)
          2'd0: p0_d = ma_q * mb_q[16:0];
          2'd1: p1_d = ma_q * mb_q[33:17];
          default: begin
            prod_d  = {17'b0, p0_q} + {p1_q, 17'b0};
            state_d = mtrap_q ? S_ACC : S_INTERP;
          end
        endcase
      end
      S_INTERP: begin
        case (sel_q)
          SEL_MAIN: begin
            res_d   = ev;
            state_d = S_FIN;
          end
          SEL_PAIR1: begin
            e1_d    = ev;
            xd_d    = b_q;
            sel_d   = SEL_PAIR2;
            addr_d  = '0;
            state_d = S_SEARCH;
          end
          SEL_PAIR2: begin
            mul_go  = 1'b1;
            mtrap_s = 1'b1;
            ma_s    = sx(e1_q) + sx(ev);
            mb_s    = sx(b_q) - sx(a_q);
          end
          SEL_EDGE1: begin
            e1_d    = ev;
            addr_d  = cnt1_q;
            state_d = S_EDGE;
          end
          SEL_EDGE2: begin
            e1_d    = ev;
            addr_d  = id2;
            state_d = S_EDGE;
          end
          default: state_d = S_FIN;
        endcase
      end
      S_BODY: begin
        if (k_q < id2) begin
          addr_d  = k_q;
          state_d = S_TRD0;
        end else begin
          state_d = S_E1CHK;
        end
      end
      S_TRD0: begin
        prev_x_d = x_rd;
        prev_y_d = y_rd;
        addr_d   = k_q + AddrW'(1);
        state_d  = S_TRD1;
      end
      S_TRD1: begin
        mul_go  = 1'b1;
        mtrap_s = 1'b1;
        ma_s    = sx(prev_y_q) + sx(y_rd);
        mb_s    = sx(x_rd) - sx(prev_x_q);
        k_d     = k_q + AddrW'(1);
      end
      S_EDGE: begin
        mul_go  = 1'b1;
        mtrap_s = 1'b1;
        if (sel_q == SEL_EDGE1) begin
          ma_s = sx(e1_q) + sx(y_rd);
          mb_s = sx(x_rd) - sx(a_q);
        end else begin
          ma_s = sx(y_rd) + sx(e1_q);
          mb_s = sx(b_q) - sx(x_rd);
        end
      end
      S_ACC: begin
        sum_d = mneg_q ? sum_q - $signed(hp) : sum_q + $signed(hp);
        case (sel_q)
          SEL_BODY:  state_d = S_BODY;
          SEL_EDGE1: state_d = S_E2CHK;
          default:   state_d = S_FIN;
        endcase
      end
      S_E1CHK: begin
        if (cnt1_q != '0) begin
          xd_d    = a_q;
          sel_d   = SEL_EDGE1;
          addr_d  = '0;
          state_d = S_SEARCH;
        end else begin
          state_d = S_E2CHK;
        end
      end
      S_E2CHK: begin
        if (id2 != last) begin
          xd_d    = b_q;
          sel_d   = SEL_EDGE2;
          addr_d  = '0;
          state_d = S_SEARCH;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_st_d    = st_q;
          if (func_q == FN_INTEG) begin
            if (sum_q > SumMax) begin
              out_res_d = 32'sh7fff_ffff;
            end else if (sum_q < SumMin) begin
              out_res_d = 32'sh8000_0000;
            end else begin
              out_res_d = sum_q[31:0];
            end
          end else begin
            out_res_d = res_q;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (mul_go) begin
      ma_d    = ma_s[33] ? 34'(-ma_s) : ma_s;
      mb_d    = mb_s[33] ? 34'(-mb_s) : mb_s;
      mneg_d  = ma_s[33] ^ mb_s[33];
      mtrap_d = mtrap_s;
      mcnt_d  = '0;
      state_d = S_MUL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_CLAMP;
      points_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      points_q    <= points_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q <= sel_d;  out_res_q <= out_res_d;  out_st_q <= out_st_d;
    func_q <= func_d;  idx_q <= idx_d;  a_q <= a_d;  b_q <= b_d;  addr_q <= addr_d;
    prev_x_q <= prev_x_d;  prev_y_q <= prev_y_d;
    x0_q <= x0_d;  y0_q <= y0_d;  xl_q <= xl_d;  yl_q <= yl_d;
    cnt1_q <= cnt1_d;  cnt2_q <= cnt2_d;  k_q <= k_d;
    xd_q <= xd_d;  yi_q <= yi_d;  e1_q <= e1_d;
    rem_q <= rem_d;  dsh_q <= dsh_d;  div_s_q <= div_s_d;  quo_q <= quo_d;  dcnt_q <= dcnt_d;
    dmod_q <= dmod_d;  dneg_q <= dneg_d;  dyneg_q <= dyneg_d;  ady_q <= ady_d;
    ma_q <= ma_d;  mb_q <= mb_d;  mneg_q <= mneg_d;  mtrap_q <= mtrap_d;  mcnt_q <= mcnt_d;
    p0_q <= p0_d;  p1_q <= p1_d;  prod_q <= prod_d;  sum_q <= sum_d;
    res_q <= res_d;  st_q <= st_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_res_q;
  assign status_o       = out_st_q;

  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> rem_q < div_s_q)
    else $error("Divider remainder is not below the divisor.");

  a_frac_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FRAC |-> quo_q <= 32'h8000_0000)
    else $error("Interpolation fraction exceeds one.");

  a_search_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SEARCH |-> addr_q <= last)
    else $error("Interval search ran past the last point.");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Block did not turn busy after taking a word.");

endmodule

>>> tb/sv/testbench.sv
module testbench;
  import itli_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic        cfg_idx;
    logic [4:0]  cfg_val;
    logic [1:0]  func;
    logic [3:0]  slot;
    logic [31:0] xa;
    logic [31:0] xb;
    bit          typed;
    logic [31:0] typed_value;
    logic [2:0]  typed_status;
  } row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              func_i;
  logic [AddrW-1:0]        point_index_i;
  logic signed [DataW-1:0] abscissa_i;
  logic signed [DataW-1:0] second_operand_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [DataW-1:0] result_value_o;
  logic [2:0]              status_o;
  logic                    cfg_we_i;
  logic                    cfg_idx_i;
  logic [4:0]              cfg_wdata_i;

  interp_table_lookup_integrate dut (.*);

  logic [1:0]  mode_sh;
  logic [4:0]  npts_sh;
  longint      tbl_x[TableDepth];
  longint      tbl_y[TableDepth];
  logic [31:0] want_value_q[$];
  logic [2:0]  want_status_q[$];
  int          errors;
  bit          calm;
  bit          typed_now;
  logic [31:0] typed_value_now;
  logic [2:0]  typed_status_now;
  row_t        rows[$];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic longint half_prod(longint a, longint b);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [127:0] m;
    longint       r;
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    m = {64'd0, ua} * {64'd0, ub};
    r = longint'(m[80:17]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint eval_point(longint x, int n, output logic [2:0] st);
    longint      x0;
    longint      xl;
    longint      xd;
    longint      rem;
    longint      dx;
    longint      dy;
    logic [63:0] num;
    logic [63:0] f;
    logic [63:0] ady;
    logic [63:0] mag;
    int          i;
    x0 = tbl_x[0];
    xl = tbl_x[n-1];
    xd = x;
    i = 0;
    st = ST_OK;
    if (x < x0 || x > xl) begin
      if (mode_sh == MODE_ERROR) begin
        st = ST_RANGE;
        return 0;
      end
      if (mode_sh == MODE_WARN) st = (x < x0) ? ST_UNDER : ST_OVER;
      if (mode_sh != MODE_REPEAT) return (x < x0) ? tbl_y[0] : tbl_y[n-1];
      if (xl == x0) begin
        xd = x0;
      end else begin
        rem = (x - x0) % (xl - x0);
        if (rem < 0) rem += xl - x0;
        xd = x0 + rem;
      end
    end
    if (n == 1) return tbl_y[0];
    while (i + 1 < n && tbl_x[i+1] < xd) i++;
    dx = tbl_x[i+1] - tbl_x[i];
    dy = tbl_y[i+1] - tbl_y[i];
    num = 64'(xd - tbl_x[i]) << 31;
    f = num / 64'(dx);
    ady = dy < 0 ? -dy : dy;
    mag = (f * ady) >> 31;
    return dy < 0 ? tbl_y[i] - longint'(mag) : tbl_y[i] + longint'(mag);
  endfunction

  function automatic longint integral(longint x1, longint x2, int n);
    longint     sum;
    logic [2:0] st;
    int         id1;
    int         id2;
    sum = 0;
    id1 = 0;
    id2 = n - 1;
    if (x1 > tbl_x[n-1] || x2 < tbl_x[0]) return 0;
    while (id1 < n - 1 && tbl_x[id1] < x1) id1++;
    while (id2 >= 1 && tbl_x[id2] > x2) id2--;
    if (id1 == id2 + 1)
      return half_prod(eval_point(x1, n, st) + eval_point(x2, n, st), x2 - x1);
    for (int i = id1; i < id2; i++)
      sum += half_prod(tbl_y[i] + tbl_y[i+1], tbl_x[i+1] - tbl_x[i]);
    if (id1 > 0) sum += half_prod(eval_point(x1, n, st) + tbl_y[id1], tbl_x[id1] - x1);
    if (id2 < n - 1) sum += half_prod(tbl_y[id2] + eval_point(x2, n, st), x2 - tbl_x[id2]);
    return sum;
  endfunction

  task automatic predict_word(input logic [1:0] fn, input logic [3:0] slot,
                              input longint a, input longint b,
                              output logic [31:0] value, output logic [2:0] st);
    longint r;
    bit     ok;
    int     n;
    r = 0;
    st = ST_OK;
    n = npts_sh;
    if (fn == FN_LOAD) begin
      tbl_x[slot] = a;
      tbl_y[slot] = b;
      if (slot > 0 && a <= tbl_x[slot-1]) st = ST_FAULT;
    end else if (fn == FN_EVAL || fn == FN_INTEG) begin
      ok = (n != 0 && n <= TableDepth);
      for (int i = 1; ok && i < n; i++)
        if (tbl_x[i] <= tbl_x[i-1]) ok = 0;
      if (!ok) begin
        st = ST_FAULT;
      end else if (fn == FN_EVAL) begin
        r = eval_point(a, n, st);
      end else begin
        r = integral(a, b, n);
        if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
        if (r < -64'sh8000_0000) r = -64'sh8000_0000;
      end
    end
    value = r[31:0];
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    logic [31:0] v;
    logic [2:0]  s;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_BOUNDS) mode_sh = cfg_wdata_i[1:0];
        else npts_sh = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_o) begin
        predict_word(func_i, point_index_i, longint'(abscissa_i),
                     longint'(second_operand_i), v, s);
        if (typed_now) begin
          v = typed_value_now;
          s = typed_status_now;
        end
        want_value_q.push_back(v);
        want_status_q.push_back(s);
      end
      if (out_valid_o && !out_stall_i) begin
        if (want_value_q.size() == 0) begin
          report_mismatch("unexpected word", result_value_o, 32'd0);
        end else begin
          v = want_value_q.pop_front();
          s = want_status_q.pop_front();
          if (result_value_o !== v) report_mismatch("result_value", result_value_o, v);
          if (status_o !== s) report_mismatch("status", 32'(status_o), 32'(s));
        end
      end
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= !rst_ni ? 1'b0 : (!calm && $urandom_range(0, 99) < 26);
  end

  task automatic drain();
    in_valid_i = 1'b0;
    while (want_value_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [4:0] val);
    drain();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic send_word(input logic [1:0] fn, input logic [3:0] slot,
                           input logic [31:0] a, input logic [31:0] b, input bit typed,
                           input logic [31:0] tv, input logic [2:0] ts);
    if (!calm) begin
      while ($urandom_range(0, 99) < 26) begin
        in_valid_i = 1'b0;
        @(negedge clk_i);
      end
    end
    func_i = fn;
    point_index_i = slot;
    abscissa_i = a;
    second_operand_i = b;
    typed_now = typed;
    typed_value_now = tv;
    typed_status_now = ts;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic void put_cfg(input logic idx, input logic [4:0] val);
    row_t r;
    r = '{kind: ROW_CFG, default: '0};
    r.cfg_idx = idx;
    r.cfg_val = val;
    rows.push_back(r);
  endfunction

  function automatic void put_word(input logic [1:0] fn, input logic [3:0] slot,
                                   input logic [31:0] a, input logic [31:0] b,
                                   input bit typed, input logic [31:0] tv,
                                   input logic [2:0] ts);
    row_t r;
    r = '{kind: ROW_WORD, default: '0};
    r.func = fn;
    r.slot = slot;
    r.xa = a;
    r.xb = b;
    r.typed = typed;
    r.typed_value = tv;
    r.typed_status = ts;
    rows.push_back(r);
  endfunction

  function automatic logic [31:0] pick_x();
    longint lo;
    longint hi;
    longint span;
    longint x;
    int     k;
    k = (npts_sh == 0 || npts_sh > TableDepth) ? TableDepth : npts_sh;
    lo = tbl_x[0];
    hi = tbl_x[k-1];
    if (hi < lo) hi = lo;
    span = hi - lo;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        x = lo - span / 4 + longint'({$urandom, $urandom} % (span + span / 2 + 1));
        if (x > 64'sh7FFF_FFFF) x = 64'sh7FFF_FFFF;
        if (x < -64'sh8000_0000) x = -64'sh8000_0000;
      end
      6: x = tbl_x[$urandom_range(0, k - 1)];
      default: x = longint'(signed'($urandom));
    endcase
    return x[31:0];
  endfunction

  task automatic reload_table(inout int sent);
    int     s;
    longint base;
    longint x;
    logic [31:0] y;
    s = $urandom_range(0, 27);
    base = -64'sh8000_0000 + longint'($urandom % (64'h1_0000_0000 - (64'd16 << s)));
    x = base;
    for (int i = 0; i < TableDepth; i++) begin
      y = ($urandom_range(0, 1) == 0) ? $urandom : 32'($urandom_range(0, 1 << 20) - (1 << 19));
      send_word(FN_LOAD, 4'(i), x[31:0], y, 0, '0, '0);
      x += $urandom_range(1, 1 << s);
      sent++;
    end
  endtask

  initial begin
    int       sent;
    int       phase;
    int       cnt;
    int       pick;
    logic [4:0] n;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = FN_LOAD;
    point_index_i = '0;
    abscissa_i = '0;
    second_operand_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_BOUNDS;
    cfg_wdata_i = '0;
    mode_sh = MODE_CLAMP;
    npts_sh = '0;
    errors = 0;
    calm = 0;
    typed_now = 0;
    typed_value_now = '0;
    typed_status_now = ST_OK;
    foreach (tbl_x[i]) begin
      tbl_x[i] = 0;
      tbl_y[i] = 0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    put_word(FN_EVAL, 0, 32'h0, 32'h0, 1, 32'd0, ST_FAULT);
    put_word(2'd3, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'd0, ST_OK);
    put_word(FN_LOAD, 0, 32'hFFFE_0000, 32'h0001_0000, 1, 32'd0, ST_OK);
    put_word(FN_LOAD, 1, 32'h0000_0000, 32'h0002_0000, 1, 32'd0, ST_OK);
    put_word(FN_LOAD, 2, 32'h0001_0000, 32'hFFFF_0000, 1, 32'd0, ST_OK);
    put_word(FN_LOAD, 3, 32'h0003_0000, 32'h7FFF_FFFF, 1, 32'd0, ST_OK);
    put_cfg(CFG_POINTS, 5'd4);
    put_cfg(CFG_BOUNDS, MODE_CLAMP);
    put_word(FN_EVAL, 0, 32'h8000_0000, 32'h0, 1, 32'h0001_0000, ST_OK);
    put_word(FN_EVAL, 0, 32'h7FFF_FFFF, 32'h0, 1, 32'h7FFF_FFFF, ST_OK);
    put_word(FN_EVAL, 0, 32'h0000_8000, 32'h0, 0, '0, '0);
    put_cfg(CFG_BOUNDS, MODE_WARN);
    put_word(FN_EVAL, 0, 32'h8000_0000, 32'h0, 1, 32'h0001_0000, ST_UNDER);
    put_word(FN_EVAL, 0, 32'h7FFF_FFFF, 32'h0, 1, 32'h7FFF_FFFF, ST_OVER);
    put_cfg(CFG_BOUNDS, MODE_ERROR);
    put_word(FN_EVAL, 0, 32'h8000_0000, 32'h0, 1, 32'd0, ST_RANGE);
    put_cfg(CFG_BOUNDS, MODE_REPEAT);
    put_word(FN_EVAL, 0, 32'hFFFB_0000, 32'h0, 0, '0, '0);
    put_word(FN_EVAL, 0, 32'h7FFF_FFFF, 32'h0, 0, '0, '0);
    put_word(FN_INTEG, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, '0, '0);
    put_word(FN_INTEG, 0, 32'h0002_0000, 32'hFFFF_0000, 0, '0, '0);
    put_word(FN_INTEG, 0, 32'h0004_0000, 32'h0005_0000, 1, 32'd0, ST_OK);
    put_word(FN_INTEG, 0, 32'h0000_4000, 32'h0000_8000, 0, '0, '0);
    put_word(FN_LOAD, 2, 32'hFFFD_0000, 32'h0, 1, 32'd0, ST_FAULT);
    put_word(FN_EVAL, 0, 32'h0, 32'h0, 1, 32'd0, ST_FAULT);
    put_word(FN_LOAD, 2, 32'h0001_0000, 32'hFFFF_0000, 1, 32'd0, ST_OK);
    put_cfg(CFG_POINTS, 5'd1);
    put_word(FN_EVAL, 0, 32'h1234_5678, 32'h0, 0, '0, '0);
    put_cfg(CFG_POINTS, 5'd31);
    put_word(FN_INTEG, 0, 32'h0, 32'h0001_0000, 1, 32'd0, ST_FAULT);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) write_reg(rows[i].cfg_idx, rows[i].cfg_val);
      else send_word(rows[i].func, rows[i].slot, rows[i].xa, rows[i].xb,
                     rows[i].typed, rows[i].typed_value, rows[i].typed_status);
    end

    sent = 0;
    phase = 0;
    while (sent < 600) begin
      write_reg(CFG_BOUNDS, (phase < 4) ? 5'(phase) : 5'($urandom_range(0, 3)));
      pick = $urandom_range(0, 9);
      if (phase % 7 == 5) n = (pick < 3) ? 5'd0 : (pick < 6) ? 5'd1 : 5'($urandom_range(17, 31));
      else if (pick == 0) n = 5'd16;
      else if (pick == 1) n = 5'd2;
      else n = 5'($urandom_range(2, 16));
      write_reg(CFG_POINTS, n);
      calm = (phase == 3);
      if (phase == 0 || $urandom_range(0, 2) == 0) reload_table(sent);
      cnt = $urandom_range(25, 50);
      for (int k = 0; k < cnt; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 4)
          send_word(FN_LOAD, 4'($urandom), $urandom, $urandom, 0, '0, '0);
        else if (pick < 7)
          send_word(2'd3, 4'($urandom), $urandom, $urandom, 0, '0, '0);
        else if (pick < 55)
          send_word(FN_EVAL, 4'($urandom), pick_x(), $urandom, 0, '0, '0);
        else
          send_word(FN_INTEG, 4'($urandom), pick_x(), pick_x(), 0, '0, '0);
        sent++;
      end
      phase++;
    end
    calm = 0;
    drain();
    repeat (200) @(negedge clk_i);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

>>> files.f
src/itli_pkg.sv
src/itli_ram.sv
src/interp_table_lookup_integrate.sv
tb/sv/testbench.sv
